FILE: hw/rtl/gsa_pkg.sv
// shared types and constants for the generational slot allocator
`timescale 1ns / 1ps

package gsa_pkg;

    localparam int SLOT_COUNT_DEF = 512;
    localparam int GEN_W          = 16;
    localparam int SLOT_IN_W      = 16;
    localparam int SLOT_OUT_W     = 9;
    localparam int HW_W           = 10;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_INVALID = 2'd2
    } gsa_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STACK,
        S_SLOT
    } gsa_state_t;

    // commands to the free stack
    typedef struct packed {
        logic rd;
        logic pop;
        logic push;
    } gsa_stk_cmd_t;

    // one slot table entry
    typedef struct packed {
        logic             live;
        logic [GEN_W-1:0] gen;
    } gsa_entry_t;

endpackage

FILE: hw/rtl/gsa_stack.sv
// free slot stack: memory, fill count and low-water mark
`timescale 1ns / 1ps

module gsa_stack #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  gsa_pkg::gsa_stk_cmd_t                cmd,
    input  logic [$clog2(SLOT_COUNT)-1:0]        push_slot,
    output logic [$clog2(SLOT_COUNT)-1:0]        top_slot,
    output logic [$clog2(SLOT_COUNT+1)-1:0]      count,
    output logic [$clog2(SLOT_COUNT+1)-1:0]      low
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    logic [IW-1:0] stk_mem [SLOT_COUNT];
    logic [IW-1:0] mem_rd_reg;
    logic [CW-1:0] top_idx_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] low_reg;
    logic [CW-1:0] low_next;
    logic [CW-1:0] top_idx;

    assign top_idx = count_reg - CW'(1);

    always_comb
    begin
        count_next = count_reg;
        low_next   = low_reg;
        if (cmd.pop)
        begin
            count_next = top_idx;
            if (top_idx < low_reg)
            begin
                low_next = top_idx;
            end
        end
        else if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CW'(SLOT_COUNT);
            low_reg   <= CW'(SLOT_COUNT);
        end
        else
        begin
            count_reg <= count_next;
            low_reg   <= low_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            mem_rd_reg  <= stk_mem[top_idx[IW-1:0]];
            top_idx_reg <= top_idx;
        end
        if (cmd.push)
        begin
            stk_mem[count_reg[IW-1:0]] <= push_slot;
        end
    end

    // entries below the low mark were never written; their own index stands in as the slot
    assign top_slot = (top_idx_reg >= low_reg) ? mem_rd_reg : top_idx_reg[IW-1:0];
    assign count    = count_reg;
    assign low      = low_reg;

endmodule

FILE: hw/rtl/gsa_slot_table.sv
// per-slot generation and live mark memory
`timescale 1ns / 1ps

module gsa_slot_table #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rd_en,
    input  logic [$clog2(SLOT_COUNT)-1:0]      rd_addr,
    input  logic                               wr_en,
    input  logic [$clog2(SLOT_COUNT)-1:0]      wr_addr,
    input  gsa_pkg::gsa_entry_t                wr_entry,
    input  logic [$clog2(SLOT_COUNT+1)-1:0]    low,
    output gsa_pkg::gsa_entry_t                rd_entry
);

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    gsa_pkg::gsa_entry_t tbl_mem [SLOT_COUNT];
    gsa_pkg::gsa_entry_t rd_data_reg;
    logic [IW-1:0]       rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= tbl_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
        if (wr_en)
        begin
            tbl_mem[wr_addr] <= wr_entry;
        end
    end

    // slots below the low mark were never handed out: generation zero, not live
    assign rd_entry = (CW'(rd_addr_reg) < low) ? '0 : rd_data_reg;

endmodule

FILE: hw/rtl/generational_slot_allocator.sv
// generational slot allocator top level: request sequencer and result register
//
//  channel  | handshake          | fields
//  ---------+--------------------+--------------------------------------
//  request  | in_valid/in_stall  | req_type, slot_in, gen_in
//  result   | out_valid/out_stall| status, slot_out, gen_out, high_water
//
// a release reads the slot table, an allocate reads the stack, then the slot table at
// the popped slot; the next request is taken in the cycle after the result is
// written, so the block takes no new request while one is still in progress
// reset needs no clearing pass: a low-water mark on the stack tells unwritten entries
// a waiting result holds the request in its last step until out_stall drops
`timescale 1ns / 1ps

module generational_slot_allocator #(
    parameter int SLOT_COUNT = gsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              req_type,
    input  logic [gsa_pkg::SLOT_IN_W-1:0]     slot_in,
    input  logic [gsa_pkg::GEN_W-1:0]         gen_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        status,
    output logic [gsa_pkg::SLOT_OUT_W-1:0]    slot_out,
    output logic [gsa_pkg::GEN_W-1:0]         gen_out,
    output logic [gsa_pkg::HW_W-1:0]          high_water
);

    localparam int IW     = $clog2(SLOT_COUNT);
    localparam int CW     = $clog2(SLOT_COUNT + 1);
    localparam int GEN_W  = gsa_pkg::GEN_W;
    localparam int SIN_W  = gsa_pkg::SLOT_IN_W;
    localparam int SOUT_W = gsa_pkg::SLOT_OUT_W;
    localparam int HW_W   = gsa_pkg::HW_W;
    localparam int LIM_W  = SIN_W + 1;
    localparam logic [LIM_W-1:0] SLOT_LIM = LIM_W'(SLOT_COUNT);

    gsa_pkg::gsa_state_t   state_reg;
    gsa_pkg::gsa_state_t   state_next;
    gsa_pkg::gsa_stk_cmd_t stk_cmd;
    gsa_pkg::gsa_entry_t   tbl_rd_entry;
    gsa_pkg::gsa_entry_t   tbl_wr_entry;

    logic [IW-1:0]     top_slot;
    logic [IW-1:0]     push_slot;
    logic [CW-1:0]     stk_count;
    logic [CW-1:0]     stk_low;
    logic              tbl_rd_en;
    logic [IW-1:0]     tbl_rd_addr;
    logic              tbl_wr_en;
    logic [IW-1:0]     tbl_wr_addr;

    logic              req_reg;
    logic [SIN_W-1:0]  slot_in_reg;
    logic [GEN_W-1:0]  gen_in_reg;
    logic [IW-1:0]     alloc_slot_reg;
    logic [CW-1:0]     high_reg;
    logic [CW-1:0]     high_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [SOUT_W-1:0] slot_out_reg;
    logic [SOUT_W-1:0] slot_out_next;
    logic [GEN_W-1:0]  gen_out_reg;
    logic [GEN_W-1:0]  gen_out_next;
    logic [HW_W-1:0]   hw_out_reg;
    logic [HW_W-1:0]   hw_out_next;

    logic              accept;
    logic              out_free;
    logic              in_range;
    logic              rel_range;
    logic [GEN_W-1:0]  gen_new;
    logic [CW-1:0]     slot_plus1;

    gsa_stack #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_stack (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (stk_cmd),
        .push_slot (push_slot),
        .top_slot  (top_slot),
        .count     (stk_count),
        .low       (stk_low)
    );

    gsa_slot_table #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_table (
        .clk      (clk),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_wr_addr),
        .wr_entry (tbl_wr_entry),
        .low      (stk_low),
        .rd_entry (tbl_rd_entry)
    );

    assign in_stall  = (state_reg != gsa_pkg::S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_range  = ({1'b0, slot_in} < SLOT_LIM);
    assign rel_range = ({1'b0, slot_in_reg} < SLOT_LIM);
    assign gen_new   = tbl_rd_entry.gen + GEN_W'(1);
    assign slot_plus1 = CW'(alloc_slot_reg) + CW'(1);
    assign push_slot = slot_in_reg[IW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        stk_cmd        = '0;
        tbl_rd_en      = 1'b0;
        tbl_rd_addr    = slot_in[IW-1:0];
        tbl_wr_en      = 1'b0;
        tbl_wr_addr    = alloc_slot_reg;
        tbl_wr_entry   = '0;
        high_next      = high_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        slot_out_next  = slot_out_reg;
        gen_out_next   = gen_out_reg;
        hw_out_next    = hw_out_reg;

        case (state_reg)
            gsa_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (req_type == gsa_pkg::REQ_ALLOC)
                    begin
                        stk_cmd.rd = 1'b1;
                        state_next = gsa_pkg::S_STACK;
                    end
                    else
                    begin
                        tbl_rd_en  = in_range;
                        state_next = gsa_pkg::S_SLOT;
                    end
                end
            end

            gsa_pkg::S_STACK:
            begin
                tbl_rd_en   = (stk_count != '0);
                tbl_rd_addr = top_slot;
                state_next  = gsa_pkg::S_SLOT;
            end

            gsa_pkg::S_SLOT:
            begin
                if (out_free)
                begin
                    state_next     = gsa_pkg::S_IDLE;
                    out_valid_next = 1'b1;
                    slot_out_next  = '0;
                    gen_out_next   = '0;
                    if (req_reg == gsa_pkg::REQ_ALLOC)
                    begin
                        if (stk_count == '0)
                        begin
                            status_next = gsa_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_next       = gsa_pkg::ST_OK;
                            slot_out_next     = SOUT_W'(alloc_slot_reg);
                            gen_out_next      = gen_new;
                            stk_cmd.pop       = 1'b1;
                            tbl_wr_en         = 1'b1;
                            tbl_wr_entry.live = 1'b1;
                            tbl_wr_entry.gen  = gen_new;
                            if (slot_plus1 > high_reg)
                            begin
                                high_next = slot_plus1;
                            end
                        end
                    end
                    else
                    begin
                        if (rel_range && tbl_rd_entry.live
                            && (tbl_rd_entry.gen == gen_in_reg)
                            && (stk_count < CW'(SLOT_COUNT)))
                        begin
                            status_next       = gsa_pkg::ST_OK;
                            stk_cmd.push      = 1'b1;
                            tbl_wr_en         = 1'b1;
                            tbl_wr_addr       = slot_in_reg[IW-1:0];
                            tbl_wr_entry.live = 1'b0;
                            tbl_wr_entry.gen  = tbl_rd_entry.gen;
                        end
                        else
                        begin
                            status_next = gsa_pkg::ST_INVALID;
                        end
                    end
                    hw_out_next = HW_W'(high_next);
                end
            end

            default:
            begin
                state_next = gsa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gsa_pkg::S_IDLE;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg     <= req_type;
            slot_in_reg <= slot_in;
            gen_in_reg  <= gen_in;
        end
        if (state_reg == gsa_pkg::S_STACK)
        begin
            alloc_slot_reg <= top_slot;
        end
        status_reg   <= status_next;
        slot_out_reg <= slot_out_next;
        gen_out_reg  <= gen_out_next;
        hw_out_reg   <= hw_out_next;
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_out   = slot_out_reg;
    assign gen_out    = gen_out_reg;
    assign high_water = hw_out_reg;

endmodule

FILE: tb/sv/generational_slot_allocator_test.sv
// self-checking testbench for the generational slot allocator
`timescale 1ns / 1ps

module generational_slot_allocator_test;

    localparam int SLOTS       = gsa_pkg::SLOT_COUNT_DEF;
    localparam int SLOT_IN_W   = gsa_pkg::SLOT_IN_W;
    localparam int SLOT_OUT_W  = gsa_pkg::SLOT_OUT_W;
    localparam int GEN_W       = gsa_pkg::GEN_W;
    localparam int HW_W        = gsa_pkg::HW_W;
    localparam int QUIET_LIMIT = 2000;
    localparam int RUN_ROUNDS  = 20;

    typedef struct {
        gsa_pkg::gsa_status_t  status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [GEN_W-1:0]      gen;
        logic [HW_W-1:0]       hw;
    } handle_result_t;

    class slot_map_scoreboard;
        logic [GEN_W-1:0]      gen_tab [SLOTS];
        bit                    live_tab [SLOTS];
        logic [SLOT_OUT_W-1:0] free_slots [SLOTS];
        int                    free_top;
        int                    top_mark;
        handle_result_t        awaited [$];
        int                    errors;

        function new();
            for (int i = 0; i < SLOTS; i++)
            begin
                gen_tab[i]    = '0;
                live_tab[i]   = 1'b0;
                free_slots[i] = SLOT_OUT_W'(i);
            end
            free_top = SLOTS;
            top_mark = 0;
            errors   = 0;
        endfunction

        // work out the result of an accepted request and queue it
        function void note_request(logic req, logic [SLOT_IN_W-1:0] slot_req,
                                   logic [GEN_W-1:0] gen_req);
            handle_result_t        res;
            logic [SLOT_OUT_W-1:0] popped;
            res.status = gsa_pkg::ST_INVALID;
            res.slot   = '0;
            res.gen    = '0;
            if (req == gsa_pkg::REQ_ALLOC)
            begin
                if (free_top == 0)
                begin
                    res.status = gsa_pkg::ST_FULL;
                end
                else
                begin
                    free_top--;
                    popped = free_slots[free_top];
                    gen_tab[popped]  = gen_tab[popped] + 1'b1;
                    live_tab[popped] = 1'b1;
                    if (int'(popped) + 1 > top_mark)
                        top_mark = int'(popped) + 1;
                    res.status = gsa_pkg::ST_OK;
                    res.slot   = popped;
                    res.gen    = gen_tab[popped];
                end
            end
            else if (slot_req < SLOTS && gen_tab[slot_req] == gen_req &&
                     live_tab[slot_req] && free_top < SLOTS)
            begin
                live_tab[slot_req]   = 1'b0;
                free_slots[free_top] = SLOT_OUT_W'(slot_req);
                free_top++;
                res.status = gsa_pkg::ST_OK;
            end
            res.hw = HW_W'(top_mark);
            awaited.push_back(res);
        endfunction

        function void check_result(logic [1:0] st, logic [SLOT_OUT_W-1:0] sl,
                                   logic [GEN_W-1:0] gn, logic [HW_W-1:0] hw);
            handle_result_t res;
            if (awaited.size() == 0)
            begin
                $error("result with nothing expected: status %0d slot %0d", st, sl);
                errors++;
                return;
            end
            res = awaited.pop_front();
            if (st !== res.status)
            begin
                $error("status expected %0d got %0d", res.status, st);
                errors++;
            end
            if (sl !== res.slot)
            begin
                $error("slot_out expected %0d got %0d", res.slot, sl);
                errors++;
            end
            if (gn !== res.gen)
            begin
                $error("gen_out expected %0d got %0d", res.gen, gn);
                errors++;
            end
            if (hw !== res.hw)
            begin
                $error("high_water expected %0d got %0d", res.hw, hw);
                errors++;
            end
        endfunction

        function bit pick_live(output logic [SLOT_OUT_W-1:0] found);
            int start;
            start = $urandom_range(0, SLOTS - 1);
            found = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (live_tab[(start + i) % SLOTS])
                begin
                    found = SLOT_OUT_W'((start + i) % SLOTS);
                    return 1'b1;
                end
            end
            return 1'b0;
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  req_type = gsa_pkg::REQ_ALLOC;
    logic [SLOT_IN_W-1:0]  slot_in = '0;
    logic [GEN_W-1:0]      gen_in = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            status;
    logic [SLOT_OUT_W-1:0] slot_out;
    logic [GEN_W-1:0]      gen_out;
    logic [HW_W-1:0]       high_water;

    slot_map_scoreboard sb = new();
    bit                 idle_on = 1'b1;
    int                 quiet = 0;

    generational_slot_allocator u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .slot_in    (slot_in),
        .gen_in     (gen_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot_out   (slot_out),
        .gen_out    (gen_out),
        .high_water (high_water)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 25);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, slot_out, gen_out, high_water);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    // present one request and hold it until the transfer
    task automatic send_request(input logic req, input logic [SLOT_IN_W-1:0] slot_v,
                                input logic [GEN_W-1:0] gen_v);
        if (idle_on && $urandom_range(0, 99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        slot_in  <= slot_v;
        gen_in   <= gen_v;
        do @(posedge clk); while (in_stall);
        sb.note_request(req, slot_v, gen_v);
    endtask

    task automatic send_alloc();
        send_request(gsa_pkg::REQ_ALLOC, SLOT_IN_W'($urandom), GEN_W'($urandom));
    endtask

    task automatic send_mixed(input int alloc_pct);
        logic [SLOT_OUT_W-1:0] s;
        int                    pick;
        pick = $urandom_range(0, 99);
        if (pick < alloc_pct)
        begin
            send_alloc();
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70 && sb.pick_live(s))
            begin
                send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(s), sb.gen_tab[s]);
            end
            else if (pick < 80 && sb.pick_live(s))
            begin
                // right slot, stale or future generation
                send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(s),
                             sb.gen_tab[s] ^ GEN_W'($urandom_range(1, 65535)));
            end
            else if (pick < 90)
            begin
                s = SLOT_OUT_W'($urandom_range(0, SLOTS - 1));
                send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(s), sb.gen_tab[s]);
            end
            else
            begin
                send_request(gsa_pkg::REQ_RELEASE,
                             SLOT_IN_W'($urandom_range(SLOTS, 65535)),
                             GEN_W'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rejects before any allocation, then the top slot
        send_request(gsa_pkg::REQ_RELEASE, 16'd0, 16'd0);
        send_request(gsa_pkg::REQ_RELEASE, 16'hFFFF, 16'hFFFF);
        send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(SLOTS), 16'd0);
        send_request(gsa_pkg::REQ_ALLOC, 16'hFFFF, 16'hFFFF);
        send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(SLOTS - 1), 16'd0);
        send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(SLOTS - 1), 16'd1);
        send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(SLOTS - 1), 16'd1);
        send_request(gsa_pkg::REQ_ALLOC, 16'd0, 16'd0);
        send_request(gsa_pkg::REQ_ALLOC, 16'h5555, 16'hAAAA);
        send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(SLOTS - 2), 16'hFFFF);
        send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(SLOTS - 2), 16'd1);
        send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(SLOTS - 1), 16'd2);
        send_request(gsa_pkg::REQ_RELEASE, 16'd0, 16'd1);

        // cycle one slot through allocate and release, back to back
        idle_on = 1'b0;
        for (int i = 0; i < RUN_ROUNDS; i++)
        begin
            send_alloc();
            send_request(gsa_pkg::REQ_RELEASE, SLOT_IN_W'(SLOTS - 1),
                         sb.gen_tab[SLOTS - 1]);
        end
        idle_on = 1'b1;

        repeat (100) send_mixed(55);

        // let the block drain before going on
        in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);

        // fill every slot, then knock on the full stack
        while (sb.free_top != 0)
        begin
            if ($urandom_range(0, 99) < 90)
                send_alloc();
            else
                send_mixed(0);
        end
        repeat (12) send_alloc();
        send_mixed(0);
        send_alloc();

        repeat (100) send_mixed(25);

        in_valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: generational_slot_allocator.f
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_stack.sv
hw/rtl/gsa_slot_table.sv
hw/rtl/generational_slot_allocator.sv
tb/sv/generational_slot_allocator_test.sv
